@@ hdl/wsg_pkg.sv @@
// shared types, constants and shape tables of the waveform sample generator
// depends on nothing; used by every module of the block
`default_nettype none

package wsg_pkg;

  // buffer and display geometry
  localparam int unsigned POINTS = 256;
  localparam int unsigned HEIGHT = 170;

  localparam logic [7:0]         SAMPLE_MAX = 8'(HEIGHT);
  localparam logic [6:0]         CENTRE     = 7'(HEIGHT / 2);
  localparam logic signed [18:0] CENTRE_Q8  = 19'((HEIGHT / 2) * 256);

  // configuration limits
  localparam logic [11:0] FULL_MV    = 12'd3300;
  localparam logic [4:0]  MAX_CYCLES = 5'd20;

  // floor(x / 3300) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2**19
  localparam logic [19:0] RECIP_M     = 20'd650753;
  localparam int unsigned RECIP_SHIFT = 31;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SAW      = 2'd2,
    SHAPE_SQUARE   = 2'd3
  } shape_e;

  typedef enum logic [1:0] {
    CFG_WAVE_SHAPE      = 2'd0,
    CFG_CYCLES_SHOWN    = 2'd1,
    CFG_PEAK_TO_PEAK_MV = 2'd2
  } cfg_index_e;

  // after the phase stage
  typedef struct packed {
    logic [7:0]  phase;
    logic [18:0] amp_scaled;
    logic        flat;
  } phase_t;

  // after the shape stage: level is unsigned q1.8
  typedef struct packed {
    logic [8:0] level;
    logic [6:0] swing_gain;
    logic       flat;
  } level_t;

  // after the swing multiply: signed q8 offset from the centre line
  typedef struct packed {
    logic signed [18:0] swing;
    logic               flat;
  } swing_t;

  // rounded 128*sin over a quarter period, 65 points
  function automatic logic [7:0] quarter_sine(input logic [6:0] i);
    logic [7:0] r;
    case (i)
      7'd0:  r = 8'd0;    7'd1:  r = 8'd3;    7'd2:  r = 8'd6;    7'd3:  r = 8'd9;
      7'd4:  r = 8'd13;   7'd5:  r = 8'd16;   7'd6:  r = 8'd19;   7'd7:  r = 8'd22;
      7'd8:  r = 8'd25;   7'd9:  r = 8'd28;   7'd10: r = 8'd31;   7'd11: r = 8'd34;
      7'd12: r = 8'd37;   7'd13: r = 8'd40;   7'd14: r = 8'd43;   7'd15: r = 8'd46;
      7'd16: r = 8'd49;   7'd17: r = 8'd52;   7'd18: r = 8'd55;   7'd19: r = 8'd58;
      7'd20: r = 8'd60;   7'd21: r = 8'd63;   7'd22: r = 8'd66;   7'd23: r = 8'd68;
      7'd24: r = 8'd71;   7'd25: r = 8'd74;   7'd26: r = 8'd76;   7'd27: r = 8'd79;
      7'd28: r = 8'd81;   7'd29: r = 8'd84;   7'd30: r = 8'd86;   7'd31: r = 8'd88;
      7'd32: r = 8'd91;   7'd33: r = 8'd93;   7'd34: r = 8'd95;   7'd35: r = 8'd97;
      7'd36: r = 8'd99;   7'd37: r = 8'd101;  7'd38: r = 8'd103;  7'd39: r = 8'd105;
      7'd40: r = 8'd106;  7'd41: r = 8'd108;  7'd42: r = 8'd110;  7'd43: r = 8'd111;
      7'd44: r = 8'd113;  7'd45: r = 8'd114;  7'd46: r = 8'd116;  7'd47: r = 8'd117;
      7'd48: r = 8'd118;  7'd49: r = 8'd119;  7'd50: r = 8'd121;  7'd51: r = 8'd122;
      7'd52: r = 8'd122;  7'd53: r = 8'd123;  7'd54: r = 8'd124;  7'd55: r = 8'd125;
      7'd56: r = 8'd126;  7'd57: r = 8'd126;  7'd58: r = 8'd127;  7'd59: r = 8'd127;
      7'd60: r = 8'd127;  7'd61: r = 8'd128;  7'd62: r = 8'd128;  7'd63: r = 8'd128;
      7'd64: r = 8'd128;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // full period by mirror symmetry of the quarter table
  function automatic logic [8:0] sine_level(input logic [7:0] p);
    logic [8:0] r;
    case (p[7:6])
      2'd0:    r = 9'd128 + 9'(quarter_sine({1'b0, p[5:0]}));
      2'd1:    r = 9'd128 + 9'(quarter_sine(7'(8'd128 - p)));
      2'd2:    r = 9'd128 - 9'(quarter_sine({1'b0, p[5:0]}));
      default: r = 9'd128 - 9'(quarter_sine(7'(8'd0 - p)));
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/wsg_phase.sv @@
// first pipeline stage: phase fraction and scaled amplitude
// depends on wsg_pkg
`default_nettype none

module wsg_phase (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic                  nxt_en_i,
  input  wire logic [7:0]            point_index_i,
  input  wire logic [4:0]            cycles_i,
  input  wire logic [11:0]           mv_i,
  output      logic                  en_o,
  output      logic                  vld_o,
  output      wsg_pkg::phase_t       data_o
);

  logic            vld_q;
  wsg_pkg::phase_t data_q, data_d;
  logic [12:0]     prod;

  assign en_o = !vld_q || nxt_en_i;

  always_comb begin
    prod              = 13'(point_index_i) * 13'(cycles_i);
    // modulo the 256-point buffer is the low byte
    data_d.phase      = prod[7:0];
    data_d.amp_scaled = 19'(mv_i) * 19'(wsg_pkg::CENTRE);
    data_d.flat       = (cycles_i == 5'd0) || (mv_i == 12'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && vld_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hdl/wsg_shape.sv @@
// second pipeline stage: shape level and half amplitude by reciprocal multiply
// depends on wsg_pkg
`default_nettype none

module wsg_shape (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic                  nxt_en_i,
  input  wire wsg_pkg::phase_t       data_i,
  input  wire wsg_pkg::shape_e       shape_i,
  output      logic                  en_o,
  output      logic                  vld_o,
  output      wsg_pkg::level_t       data_o
);

  logic            vld_q;
  wsg_pkg::level_t data_q, data_d;
  logic [38:0]     recip_prod;
  logic [6:0]      half_raw;
  logic [7:0]      p;

  assign en_o = !vld_q || nxt_en_i;
  assign p    = data_i.phase;

  always_comb begin
    case (shape_i)
      wsg_pkg::SHAPE_SINE:     data_d.level = wsg_pkg::sine_level(p);
      wsg_pkg::SHAPE_TRIANGLE: data_d.level = p[7] ? 9'({p, 1'b0} - 9'd256)
                                                   : 9'(10'd256 - {1'b0, p, 1'b0});
      wsg_pkg::SHAPE_SAW:      data_d.level = {1'b0, p};
      wsg_pkg::SHAPE_SQUARE:   data_d.level = p[7] ? 9'd0 : 9'd256;
      default:                 data_d.level = 9'd0;
    endcase
    recip_prod        = 39'(data_i.amp_scaled) * 39'(wsg_pkg::RECIP_M);
    half_raw          = 7'(recip_prod >> wsg_pkg::RECIP_SHIFT);
    // small nonzero amplitudes still swing by one
    data_d.swing_gain = (half_raw == 7'd0) ? 7'd1 : half_raw;
    data_d.flat       = data_i.flat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && vld_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hdl/wsg_mix.sv @@
// third and fourth pipeline stages: signed swing, centre offset, clamp, output register
// depends on wsg_pkg
`default_nettype none

module wsg_mix (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic                  out_stall_i,
  input  wire wsg_pkg::level_t       data_i,
  output      logic                  en_o,
  output      logic                  out_valid_o,
  output      logic [7:0]            sample_o
);

  logic               swg_vld_q, out_vld_q, swg_en, out_en;
  wsg_pkg::swing_t    swg_q, swg_d;
  logic [7:0]         sample_q, sample_d;
  logic signed [10:0] delta;
  logic signed [18:0] lvl;
  logic [10:0]        lvl_int;

  assign out_en = !out_vld_q || !out_stall_i;
  assign swg_en = !swg_vld_q || out_en;
  assign en_o   = swg_en;

  always_comb begin
    // 2n - 256 spans -256..256
    delta       = $signed({1'b0, data_i.level, 1'b0}) - 11'sd256;
    swg_d.swing = 19'(delta) * 19'($signed({1'b0, data_i.swing_gain}));
    swg_d.flat  = data_i.flat;
  end

  always_comb begin
    lvl     = wsg_pkg::CENTRE_Q8 + swg_q.swing;
    lvl_int = lvl[18:8];
    if (swg_q.flat) begin
      sample_d = 8'(wsg_pkg::CENTRE);
    end else if (lvl[18]) begin
      sample_d = 8'd0;
    end else if (lvl_int > 11'(wsg_pkg::SAMPLE_MAX)) begin
      sample_d = wsg_pkg::SAMPLE_MAX;
    end else begin
      sample_d = lvl_int[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (swg_en) begin
        swg_vld_q <= vld_i;
      end
      if (out_en) begin
        out_vld_q <= swg_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (swg_en && vld_i) begin
      swg_q <= swg_d;
    end
    if (out_en && swg_vld_q) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = sample_q;

endmodule

`default_nettype wire

@@ hdl/waveform_sample_generator_core.sv @@
// Waveform sample generator: for each point index one display sample of a sine,
// triangle, sawtooth or square wave. A new transaction can be taken every clock
// unless the input stalls; each one passes four registered stages (phase, shape
// and reciprocal, swing multiply, offset and clamp into the output register).
// The four stages carry their own valid bits and close up bubbles, so a stall on
// the output only reaches the input once every stage is full. Configuration is a
// plain write port and must only change while no transaction is in flight.
// depends on wsg_pkg, wsg_phase, wsg_shape, wsg_mix
`default_nettype none

module waveform_sample_generator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // point index transactions
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  point_index_i,
  // sample transactions
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  sample_o
);

  // configuration registers, held in their clamped form
  wsg_pkg::shape_e shape_q;
  logic [4:0]      cycles_q;   // min(cycles_shown, 20)
  logic [11:0]     mv_q;       // min(peak_to_peak_mv[11:0], 3300)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= wsg_pkg::SHAPE_SINE;
      cycles_q <= 5'd0;
      mv_q     <= 12'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wsg_pkg::CFG_WAVE_SHAPE: begin
          shape_q <= wsg_pkg::shape_e'(cfg_data_i[1:0]);
        end
        wsg_pkg::CFG_CYCLES_SHOWN: begin
          cycles_q <= (cfg_data_i > 16'(wsg_pkg::MAX_CYCLES)) ? wsg_pkg::MAX_CYCLES
                                                             : cfg_data_i[4:0];
        end
        wsg_pkg::CFG_PEAK_TO_PEAK_MV: begin
          mv_q <= (cfg_data_i[11:0] > wsg_pkg::FULL_MV) ? wsg_pkg::FULL_MV
                                                        : cfg_data_i[11:0];
        end
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // stage handoff: each stage loads when empty or when the next one loads
  logic            ph_en, ph_vld, sh_en, sh_vld, mx_en;
  wsg_pkg::phase_t ph_data;
  wsg_pkg::level_t sh_data;

  wsg_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (in_valid_i),
    .nxt_en_i      (sh_en),
    .point_index_i (point_index_i),
    .cycles_i      (cycles_q),
    .mv_i          (mv_q),
    .en_o          (ph_en),
    .vld_o         (ph_vld),
    .data_o        (ph_data)
  );

  wsg_shape u_shape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (ph_vld),
    .nxt_en_i (mx_en),
    .data_i   (ph_data),
    .shape_i  (shape_q),
    .en_o     (sh_en),
    .vld_o    (sh_vld),
    .data_o   (sh_data)
  );

  // swing multiply plus the output register, which parts the two sides
  wsg_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (sh_vld),
    .out_stall_i (out_stall_i),
    .data_i      (sh_data),
    .en_o        (mx_en),
    .out_valid_o (out_valid_o),
    .sample_o    (sample_o)
  );

  // input is held off only while the first stage is full and cannot move
  assign in_stall_o = !ph_en;

`ifndef NO_ASSERTIONS
  // backpressure at the input can only come from a stalled output
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && ph_vld && sh_vld))
    else $error("input stalled without a full pipeline");

  // an accepted transaction always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ph_vld)
    else $error("accepted transaction lost at the first stage");

  // samples never leave the display range
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_o <= wsg_pkg::SAMPLE_MAX))
    else $error("sample above display height");
`endif

endmodule

`default_nettype wire

@@ sim/wsg_sample_checker.sv @@
// sample checker for the waveform sample generator: follows configuration writes,
// predicts every sample and compares the accepted ones in order
// depends on wsg_pkg for the shape and register codes and the display limits
module wsg_sample_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  point_index_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [7:0]  sample_i,
  input  wire logic        end_of_test_i,
  output int unsigned      pending_o,
  output int unsigned      fail_count_o
);

  // 128*sin over the rising quarter, rounded
  localparam logic [0:64][7:0] SINE_RISE = {
    8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,  8'd22,
    8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
    8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
    8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
    8'd91,  8'd93,  8'd95,  8'd97,  8'd99,  8'd101, 8'd103, 8'd105,
    8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
    8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
    8'd128
  };

  typedef struct packed {
    logic [7:0] point;
    logic [7:0] sample;
  } expected_point_t;

  expected_point_t pending_samples[$];
  wsg_pkg::shape_e wave;
  int unsigned     cycles_cfg;
  int unsigned     mv_cfg;
  int unsigned     queued = 0;
  int unsigned     mismatches = 0;
  bit              leftover_checked = 1'b0;

  assign pending_o    = queued;
  assign fail_count_o = mismatches;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [7:0] sample_for_point(input wsg_pkg::shape_e shape,
                                                  input int unsigned cycles,
                                                  input int unsigned mv,
                                                  input logic [7:0] point);
    int unsigned cyc, half, phase, level;
    int swing;
    cyc  = (cycles > wsg_pkg::MAX_CYCLES) ? wsg_pkg::MAX_CYCLES : cycles;
    half = (mv * (wsg_pkg::HEIGHT / 2)) / wsg_pkg::FULL_MV;
    if (mv != 0 && half == 0) half = 1;
    if (cyc == 0 || half == 0) return 8'(wsg_pkg::HEIGHT / 2);
    phase = (point * cyc) % wsg_pkg::POINTS;
    case (shape)
      wsg_pkg::SHAPE_SINE: begin
        if (phase < 64)       level = 128 + SINE_RISE[phase];
        else if (phase < 128) level = 128 + SINE_RISE[128 - phase];
        else if (phase < 192) level = 128 - SINE_RISE[phase - 128];
        else                  level = 128 - SINE_RISE[(256 - phase) & 127];
      end
      wsg_pkg::SHAPE_TRIANGLE: level = (phase < 128) ? 256 - 2 * phase : 2 * phase - 256;
      wsg_pkg::SHAPE_SAW:      level = phase;
      default:                 level = (phase < 128) ? 256 : 0;
    endcase
    swing = int'((wsg_pkg::HEIGHT / 2) * 256) + (2 * int'(level) - 256) * int'(half);
    if (swing < 0) begin
      swing = 0;
    end else begin
      swing = swing / 256;
      if (swing > int'(wsg_pkg::HEIGHT)) swing = int'(wsg_pkg::HEIGHT);
    end
    return 8'(swing);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    expected_point_t head;
    int unsigned     raw_mv;
    if (!rst_ni) begin
      wave       = wsg_pkg::SHAPE_SINE;
      cycles_cfg = 0;
      mv_cfg     = 0;
      pending_samples.delete();
      queued = 0;
    end else begin
      if (cfg_we_i) begin
        case (wsg_pkg::cfg_index_e'(cfg_index_i))
          wsg_pkg::CFG_WAVE_SHAPE:   wave = wsg_pkg::shape_e'(cfg_data_i[1:0]);
          wsg_pkg::CFG_CYCLES_SHOWN: cycles_cfg = cfg_data_i;
          wsg_pkg::CFG_PEAK_TO_PEAK_MV: begin
            raw_mv = cfg_data_i[11:0];
            mv_cfg = (raw_mv > wsg_pkg::FULL_MV) ? wsg_pkg::FULL_MV : raw_mv;
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        head.point  = point_index_i;
        head.sample = sample_for_point(wave, cycles_cfg, mv_cfg, point_index_i);
        pending_samples.push_back(head);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_samples.size() == 0) begin
          report($sformatf("sample %0d with no transaction waiting", sample_i));
        end else begin
          head = pending_samples.pop_front();
          if (sample_i !== head.sample)
            report($sformatf("point %0d gave sample %0d, expected %0d",
                             head.point, sample_i, head.sample));
        end
      end
      if (end_of_test_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_samples.size() != 0)
          report($sformatf("%0d samples never arrived", pending_samples.size()));
      end
      queued = pending_samples.size();
    end
  end

endmodule

@@ sim/waveform_sample_generator_core_test.sv @@
// testbench top for waveform_sample_generator_core: clock, reset, configuration,
// point index stimulus, output stall and the verdict
// depends on wsg_pkg, the block and wsg_sample_checker
module waveform_sample_generator_core_test;

  // index past the register list, writes there must be ignored
  localparam logic [1:0]  CFG_UNMAPPED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 8;     // pipeline is four deep
  localparam int unsigned HOLD_CYCLES  = 48;    // long output hold-off
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no transaction and no register write
  localparam int unsigned SEGMENTS     = 12;
  localparam int unsigned SEGMENT_ITEMS = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  point_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  sample_o;
  logic        end_of_test;

  int unsigned pending;
  int unsigned fail_count;

  // idle percentages for each side, set per segment by the stimulus
  int unsigned send_pct = 14;
  int unsigned recv_pct = 70;
  // one-shot request for the long output hold-off
  bit          hold_request = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  waveform_sample_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_index_i (point_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o)
  );

  wsg_sample_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .point_index_i (point_index_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_i      (sample_o),
    .end_of_test_i (end_of_test),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // output side: random stall at recv_pct, or a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // ends the run if no transaction and no register write happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_fire || out_fire || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one point index, with random idle cycles in front at send_pct;
  // returns on the edge that accepts the transaction, valid still high
  task automatic send_point(input logic [7:0] idx);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait until every expected sample has come out,
  // then let the pipeline settle before any register write
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers plus one write to the unmapped index;
  // unused upper data bits get random values
  task automatic drive_config(input wsg_pkg::shape_e shape, input logic [15:0] cycles,
                              input logic [11:0] mv);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= wsg_pkg::CFG_WAVE_SHAPE;
    cfg_data_i  <= {14'($urandom), shape};
    @(posedge clk_i);
    cfg_index_i <= wsg_pkg::CFG_CYCLES_SHOWN;
    cfg_data_i  <= cycles;
    @(posedge clk_i);
    cfg_index_i <= wsg_pkg::CFG_PEAK_TO_PEAK_MV;
    cfg_data_i  <= {4'($urandom), mv};
    @(posedge clk_i);
    cfg_index_i <= CFG_UNMAPPED;
    cfg_data_i  <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] cycles;
    logic [11:0] mv;
    int unsigned pick;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= wsg_pkg::CFG_WAVE_SHAPE;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    point_index_i <= '0;
    end_of_test   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero cycles and zero amplitude give the flat centre line
    send_point(8'd0);
    send_point(8'd255);

    // every shape over one full cycle at full amplitude, index extremes included
    for (int s = 0; s < 4; s++) begin
      wait_drained();
      drive_config(wsg_pkg::shape_e'(s), 16'd1, 12'd3300);
      send_point(8'd0);
      send_point(8'd64);
      send_point(8'd128);
      send_point(8'd255);
    end

    // cycles far above twenty and amplitude above full scale, both saturate
    wait_drained();
    drive_config(wsg_pkg::SHAPE_SINE, 16'hFFFF, 12'hFFF);
    send_point(8'd13);

    // zero amplitude with cycles set
    wait_drained();
    drive_config(wsg_pkg::SHAPE_TRIANGLE, 16'd20, 12'd0);
    send_point(8'd77);

    // zero cycles with amplitude set
    wait_drained();
    drive_config(wsg_pkg::SHAPE_SQUARE, 16'd0, 12'd3300);
    send_point(8'd200);

    // tiny amplitude, half amplitude forced up to one
    wait_drained();
    drive_config(wsg_pkg::SHAPE_SAW, 16'd3, 12'd1);
    send_point(8'd50);
    send_point(8'd85);

    // random part: segments with a fresh setting each, idling pattern by thirds
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      if (seg < SEGMENTS / 3) begin
        send_pct = 14;
        recv_pct = 70;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_pct = 70;
        recv_pct = 14;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end

      if (seg == 0) begin
        cycles = 16'hFFFF;
        mv     = 12'hFFF;
      end else if (seg == 1) begin
        cycles = 16'd1;
        mv     = 12'd1;
      end else begin
        pick = $urandom_range(9);
        if (pick == 0)      cycles = 16'd0;
        else if (pick == 1) cycles = 16'($urandom_range(65535, 21));
        else if (pick == 2) cycles = 16'd20;
        else                cycles = 16'($urandom_range(20, 1));
        pick = $urandom_range(9);
        if (pick == 0)      mv = 12'd0;
        else if (pick == 1) mv = 12'($urandom_range(4095, 3301));
        else if (pick == 2) mv = 12'($urandom_range(38, 1));
        else if (pick == 3) mv = 12'd3300;
        else                mv = 12'($urandom_range(3300, 1));
      end
      drive_config(wsg_pkg::shape_e'($urandom_range(3)), cycles, mv);

      // no idling here: hold the output off so the pipeline fills and
      // the input stalls while items keep being offered
      if (seg == 2 * SEGMENTS / 3) hold_request = 1'b1;

      repeat (SEGMENT_ITEMS) send_point(8'($urandom_range(255)));
    end

    wait_drained();
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ waveform_sample_generator_core.f @@
hdl/wsg_pkg.sv
hdl/wsg_phase.sv
hdl/wsg_shape.sv
hdl/wsg_mix.sv
hdl/waveform_sample_generator_core.sv
sim/wsg_sample_checker.sv
sim/waveform_sample_generator_core_test.sv
